### rtl/tscl_pkg.sv
`default_nettype none

package tscl_pkg;

    // Working values are unsigned magnitudes with WORK_FRAC fraction bits,
    // capped below 2^(WORK_FRAC + 32).
    localparam int WORK_FRAC  = 26;
    localparam int WORK_BITS  = WORK_FRAC + 32;
    localparam int HALF_BITS  = WORK_BITS / 2;
    localparam int MAGIC_BITS = WORK_BITS + 1;
    localparam int ACC_BITS   = 64;
    localparam int PROD_BITS  = 2 * WORK_BITS;
    localparam int QPROD_BITS = WORK_BITS + MAGIC_BITS;

    typedef logic [WORK_BITS-1:0] work_t;

    localparam work_t WORK_ONE = work_t'(1) << WORK_FRAC;

    localparam logic signed [ACC_BITS-1:0] RES_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [ACC_BITS-1:0] RES_MIN = 64'shFFFF_FFFF_8000_0000;

    typedef enum logic [1:0] {
        FUNC_SIN  = 2'd0,
        FUNC_COS  = 2'd1,
        FUNC_LN   = 2'd2,
        FUNC_NONE = 2'd3
    } func_t;

    // Per-word context that rides along the whole pipeline.
    typedef struct packed {
        func_t                       func;
        logic                        neg;
        logic                        over;
        logic signed [ACC_BITS-1:0]  acc;
        work_t                       op;
    } ctx_t;

    // What one series step hands to the next one.
    typedef struct packed {
        ctx_t   ctx;
        work_t  value;
        work_t  term;
        logic   term_neg;
        logic   term_en;
    } link_t;

    function automatic logic signed [ACC_BITS-1:0] signed_term(
        input work_t term,
        input logic  neg,
        input logic  en
    );
        logic signed [ACC_BITS-1:0] mag;
        mag = $signed({{(ACC_BITS-WORK_BITS){1'b0}}, term});
        if (!en) begin
            return '0;
        end
        return neg ? -mag : mag;
    endfunction

endpackage

`default_nettype wire

### rtl/tscl_step.sv
`default_nettype none

module tscl_step #(
    parameter int STEP          = 1,
    parameter int TRIG_TERMS    = 7,
    parameter int LOG_TERMS     = 8,
    parameter int ARG_FRAC_BITS = 28
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic             up_valid,
    input  wire tscl_pkg::link_t  up_link,
    output logic                  dn_valid,
    output tscl_pkg::link_t       dn_link
);
    import tscl_pkg::*;

    // Divisors of this step for each function.
    localparam int SIN_D = (2 * STEP) * (2 * STEP + 1);
    localparam int COS_D = (2 * STEP - 1) * (2 * STEP);
    localparam int LN_D  = STEP + 1;
    localparam int SIN_L = $clog2(SIN_D);
    localparam int COS_L = $clog2(COS_D);
    localparam int LN_L  = $clog2(LN_D);

    // Reciprocals: floor(n / d) = (n * M) >> (WORK_BITS + L) for every n below 2^WORK_BITS.
    localparam logic [127:0] SIN_M_WIDE = ((128'd1 << (WORK_BITS + SIN_L)) / SIN_D) + 128'd1;
    localparam logic [127:0] COS_M_WIDE = ((128'd1 << (WORK_BITS + COS_L)) / COS_D) + 128'd1;
    localparam logic [127:0] LN_M_WIDE  = ((128'd1 << (WORK_BITS + LN_L)) / LN_D) + 128'd1;
    localparam logic [MAGIC_BITS-1:0] SIN_M = SIN_M_WIDE[MAGIC_BITS-1:0];
    localparam logic [MAGIC_BITS-1:0] COS_M = COS_M_WIDE[MAGIC_BITS-1:0];
    localparam logic [MAGIC_BITS-1:0] LN_M  = LN_M_WIDE[MAGIC_BITS-1:0];

    localparam logic TRIG_ON  = (STEP <= TRIG_TERMS - 1);
    localparam logic LN_ON    = (STEP <= LOG_TERMS - 1);
    localparam logic STEP_ODD = ((STEP % 2) == 1);

    // Stage a: partial products of value * operand, and the previous term is summed.
    logic                          a_valid_reg;
    ctx_t                          a_ctx_reg;
    ctx_t                          a_ctx_next;
    logic [2*HALF_BITS-1:0]        a_pp00_reg;
    logic [2*HALF_BITS-1:0]        a_pp01_reg;
    logic [2*HALF_BITS-1:0]        a_pp10_reg;
    logic [2*HALF_BITS-1:0]        a_pp11_reg;
    logic [2*HALF_BITS-1:0]        a_pp00_next;
    logic [2*HALF_BITS-1:0]        a_pp01_next;
    logic [2*HALF_BITS-1:0]        a_pp10_next;
    logic [2*HALF_BITS-1:0]        a_pp11_next;
    logic [HALF_BITS-1:0]          a_v_lo;
    logic [HALF_BITS-1:0]          a_v_hi;
    logic [HALF_BITS-1:0]          a_o_lo;
    logic [HALF_BITS-1:0]          a_o_hi;

    // Stage b: full product, scaling shift and range check.
    logic                          b_valid_reg;
    ctx_t                          b_ctx_reg;
    ctx_t                          b_ctx_next;
    work_t                         b_prod_reg;
    work_t                         b_prod_next;
    logic                          b_on_reg;
    logic                          b_on_next;
    logic [PROD_BITS-1:0]          b_full;
    logic [PROD_BITS-1:0]          b_shifted;
    logic                          b_trig;

    // Stage c: partial products of the product and the divisor reciprocal.
    logic                          c_valid_reg;
    ctx_t                          c_ctx_reg;
    work_t                         c_prod_reg;
    logic                          c_on_reg;
    logic [MAGIC_BITS-1:0]         c_magic;
    logic [MAGIC_BITS-1:0]         c_qp00_reg;
    logic [MAGIC_BITS-1:0]         c_qp01_reg;
    logic [MAGIC_BITS-1:0]         c_qp10_reg;
    logic [MAGIC_BITS-1:0]         c_qp11_reg;
    logic [MAGIC_BITS-1:0]         c_qp00_next;
    logic [MAGIC_BITS-1:0]         c_qp01_next;
    logic [MAGIC_BITS-1:0]         c_qp10_next;
    logic [MAGIC_BITS-1:0]         c_qp11_next;

    // Stage d: quotient and the link to the next step.
    logic                          d_valid_reg;
    link_t                         d_link_reg;
    link_t                         d_link_next;
    logic [QPROD_BITS-1:0]         d_full;
    work_t                         d_quot;
    logic                          d_trig;

    always_comb
    begin
        a_v_lo = up_link.value[HALF_BITS-1:0];
        a_v_hi = up_link.value[WORK_BITS-1:HALF_BITS];
        a_o_lo = up_link.ctx.op[HALF_BITS-1:0];
        a_o_hi = up_link.ctx.op[WORK_BITS-1:HALF_BITS];
        a_pp00_next = (2*HALF_BITS)'(a_v_lo) * (2*HALF_BITS)'(a_o_lo);
        a_pp01_next = (2*HALF_BITS)'(a_v_lo) * (2*HALF_BITS)'(a_o_hi);
        a_pp10_next = (2*HALF_BITS)'(a_v_hi) * (2*HALF_BITS)'(a_o_lo);
        a_pp11_next = (2*HALF_BITS)'(a_v_hi) * (2*HALF_BITS)'(a_o_hi);
        a_ctx_next = up_link.ctx;
        a_ctx_next.acc = $signed(up_link.ctx.acc)
                       + signed_term(up_link.term, up_link.term_neg, up_link.term_en);
    end

    always_comb
    begin
        b_full = (PROD_BITS'(a_pp11_reg) << (2 * HALF_BITS))
               + (PROD_BITS'(a_pp01_reg) << HALF_BITS)
               + (PROD_BITS'(a_pp10_reg) << HALF_BITS)
               + PROD_BITS'(a_pp00_reg);
        b_trig = (a_ctx_reg.func == FUNC_SIN) || (a_ctx_reg.func == FUNC_COS);
        b_shifted = b_trig ? (b_full >> WORK_FRAC) : (b_full >> ARG_FRAC_BITS);
        b_on_next = (b_trig && TRIG_ON) || ((a_ctx_reg.func == FUNC_LN) && LN_ON);
        b_prod_next = b_shifted[WORK_BITS-1:0];
        b_ctx_next = a_ctx_reg;
        b_ctx_next.over = a_ctx_reg.over | (b_on_next & (|b_shifted[PROD_BITS-1:WORK_BITS]));
    end

    always_comb
    begin
        case (b_ctx_reg.func)
            FUNC_SIN: c_magic = SIN_M;
            FUNC_COS: c_magic = COS_M;
            default:  c_magic = LN_M;
        endcase
        c_qp00_next = MAGIC_BITS'(b_prod_reg[HALF_BITS-1:0])
                    * MAGIC_BITS'(c_magic[HALF_BITS-1:0]);
        c_qp01_next = MAGIC_BITS'(b_prod_reg[HALF_BITS-1:0])
                    * MAGIC_BITS'(c_magic[MAGIC_BITS-1:HALF_BITS]);
        c_qp10_next = MAGIC_BITS'(b_prod_reg[WORK_BITS-1:HALF_BITS])
                    * MAGIC_BITS'(c_magic[HALF_BITS-1:0]);
        c_qp11_next = MAGIC_BITS'(b_prod_reg[WORK_BITS-1:HALF_BITS])
                    * MAGIC_BITS'(c_magic[MAGIC_BITS-1:HALF_BITS]);
    end

    always_comb
    begin
        d_full = (QPROD_BITS'(c_qp11_reg) << (2 * HALF_BITS))
               + (QPROD_BITS'(c_qp01_reg) << HALF_BITS)
               + (QPROD_BITS'(c_qp10_reg) << HALF_BITS)
               + QPROD_BITS'(c_qp00_reg);
        case (c_ctx_reg.func)
            FUNC_SIN: d_quot = work_t'(d_full >> (WORK_BITS + SIN_L));
            FUNC_COS: d_quot = work_t'(d_full >> (WORK_BITS + COS_L));
            default:  d_quot = work_t'(d_full >> (WORK_BITS + LN_L));
        endcase
        d_trig = (c_ctx_reg.func == FUNC_SIN) || (c_ctx_reg.func == FUNC_COS);
        d_link_next.ctx   = c_ctx_reg;
        d_link_next.value = (c_ctx_reg.func == FUNC_LN) ? c_prod_reg : d_quot;
        d_link_next.term  = d_quot;
        if (d_trig)
        begin
            d_link_next.term_neg = STEP_ODD ^ ((c_ctx_reg.func == FUNC_SIN) && c_ctx_reg.neg);
        end
        else
        begin
            d_link_next.term_neg = STEP_ODD | c_ctx_reg.neg;
        end
        d_link_next.term_en = c_on_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= up_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_ctx_reg  <= a_ctx_next;
            a_pp00_reg <= a_pp00_next;
            a_pp01_reg <= a_pp01_next;
            a_pp10_reg <= a_pp10_next;
            a_pp11_reg <= a_pp11_next;
            b_ctx_reg  <= b_ctx_next;
            b_prod_reg <= b_prod_next;
            b_on_reg   <= b_on_next;
            c_ctx_reg  <= b_ctx_reg;
            c_prod_reg <= b_prod_reg;
            c_on_reg   <= b_on_reg;
            c_qp00_reg <= c_qp00_next;
            c_qp01_reg <= c_qp01_next;
            c_qp10_reg <= c_qp10_next;
            c_qp11_reg <= c_qp11_next;
            d_link_reg <= d_link_next;
        end
    end

    assign dn_valid = d_valid_reg;
    assign dn_link  = d_link_reg;

endmodule

`default_nettype wire

### rtl/taylor_sin_cos_ln.sv
// Throughput: one word per cycle; the series steps are fully pipelined, one step per
// four register stages. A two-entry output buffer takes one word while res_stall is high;
// the pipeline and arg_stall hold only while both entries are full.
// Reset: rst_n clears every valid bit asynchronously; data registers are not reset.
`default_nettype none

module taylor_sin_cos_ln #(
    parameter int TRIG_TERMS    = 7,
    parameter int LOG_TERMS     = 8,
    parameter int ARG_FRAC_BITS = 28
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         arg_valid,
    output logic              arg_stall,
    input  wire logic [1:0]   func,
    input  wire logic signed [31:0] argument,
    output logic              res_valid,
    input  wire logic         res_stall,
    output logic signed [31:0] result,
    output logic              saturated
);
    import tscl_pkg::*;

    // One series step follows another; the first term comes out of the front end, so
    // the longest series needs max(TRIG_TERMS, LOG_TERMS) - 1 steps.
    localparam int STEPS    = ((TRIG_TERMS > LOG_TERMS) ? TRIG_TERMS : LOG_TERMS) - 1;
    localparam int X2_SHIFT = 2 * ARG_FRAC_BITS - WORK_FRAC;

    // Sign of the highest-order term, used when a power or a term runs out of range.
    localparam logic TRIG_LAST_ODD = (((TRIG_TERMS - 1) % 2) == 1);
    localparam logic LOG_LAST_EVEN = ((LOG_TERMS % 2) == 0);

    // The whole pipeline moves together. It only freezes when the output buffer holds
    // two words, so a waiting result never blocks new arguments by itself.
    logic                 en;

    // Front end, stage 0: sign and magnitude of the argument.
    logic                 s0_valid_reg;
    func_t                s0_func_reg;
    logic                 s0_neg_reg;
    logic [31:0]          s0_mag_reg;
    logic [31:0]          s0_mag_next;

    // Front end, stage 1: x^2 (or |x| for the log series) and the first term.
    logic                 s1_valid_reg;
    link_t                s1_link_reg;
    link_t                s1_link_next;
    logic [63:0]          s1_square;
    work_t                s1_scaled;
    work_t                s1_x2;
    logic                 s1_trig;

    // Series steps.
    link_t                chain [0:STEPS];
    logic [STEPS:0]       chain_valid;

    // Back end: last term summed, then rounding and clamping.
    logic                 f1_valid_reg;
    ctx_t                 f1_ctx_reg;
    ctx_t                 f1_ctx_next;
    logic                 f2_valid_reg;
    logic signed [31:0]   f2_result_reg;
    logic signed [31:0]   f2_result_next;
    logic                 f2_sat_reg;
    logic                 f2_sat_next;
    logic signed [ACC_BITS-1:0] f2_rounded;
    logic                 f2_last_neg;

    // Output register and skid entry.
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic signed [31:0]   out_result_reg;
    logic                 out_sat_reg;
    logic                 skid_valid_reg;
    logic                 skid_valid_next;
    logic signed [31:0]   skid_result_reg;
    logic                 skid_sat_reg;
    logic                 out_load_f2;
    logic                 out_load_skid;
    logic                 skid_load;

    assign en        = !skid_valid_reg;
    assign arg_stall = skid_valid_reg;

    // ---------------------------------------------------------------------------------
    // Stage 0. The magnitude of the most negative argument is 2^31, which still fits
    // in 32 unsigned bits.
    // ---------------------------------------------------------------------------------
    assign s0_mag_next = argument[31] ? 32'(-argument) : argument;

    // ---------------------------------------------------------------------------------
    // Stage 1. Sine and cosine iterate on x^2 with the working scale; ln(1+x) iterates
    // on |x| itself with the argument scale. The first term is |x| (sine, ln) or one
    // (cosine), and it is carried as a pending term into the first step.
    // ---------------------------------------------------------------------------------
    assign s1_square = 64'(s0_mag_reg) * 64'(s0_mag_reg);
    assign s1_scaled = (work_t'(s0_mag_reg) << WORK_FRAC) >> ARG_FRAC_BITS;
    assign s1_x2     = work_t'(s1_square >> X2_SHIFT);

    always_comb
    begin
        s1_trig = (s0_func_reg == FUNC_SIN) || (s0_func_reg == FUNC_COS);
        s1_link_next.ctx.func = s0_func_reg;
        s1_link_next.ctx.neg  = s0_neg_reg;
        s1_link_next.ctx.over = 1'b0;
        s1_link_next.ctx.acc  = '0;
        s1_link_next.ctx.op   = s1_trig ? s1_x2 : work_t'(s0_mag_reg);
        s1_link_next.value    = (s0_func_reg == FUNC_COS) ? WORK_ONE : s1_scaled;
        s1_link_next.term     = s1_link_next.value;
        s1_link_next.term_neg = s0_neg_reg && (s0_func_reg != FUNC_COS);
        s1_link_next.term_en  = (s0_func_reg != FUNC_NONE);
    end

    // ---------------------------------------------------------------------------------
    // Series steps. Step j multiplies the running value by the operand, rescales and
    // checks the range, then divides by the step's constant through a reciprocal
    // product. Sine and cosine keep the quotient as the running value; ln keeps the
    // power and uses the quotient only as the term. Each term is added to the sum one
    // stage later, in the next step.
    // ---------------------------------------------------------------------------------
    assign chain[0]       = s1_link_reg;
    assign chain_valid[0] = s1_valid_reg;

    for (genvar j = 1; j <= STEPS; j++)
    begin : g_step
        tscl_step #(
            .STEP          (j),
            .TRIG_TERMS    (TRIG_TERMS),
            .LOG_TERMS     (LOG_TERMS),
            .ARG_FRAC_BITS (ARG_FRAC_BITS)
        ) u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .up_valid (chain_valid[j-1]),
            .up_link  (chain[j-1]),
            .dn_valid (chain_valid[j]),
            .dn_link  (chain[j])
        );
    end

    // ---------------------------------------------------------------------------------
    // Back end. The sum is rounded to 24 fraction bits, to nearest with ties toward
    // plus infinity, which is an arithmetic shift after adding two. A word whose power
    // or term ran out of range goes to the end of the range that the sign of its
    // highest-order term points at. The unused selector code gives zero.
    // ---------------------------------------------------------------------------------
    always_comb
    begin
        f1_ctx_next = chain[STEPS].ctx;
        f1_ctx_next.acc = $signed(chain[STEPS].ctx.acc)
                        + signed_term(chain[STEPS].term, chain[STEPS].term_neg,
                                      chain[STEPS].term_en);
    end

    always_comb
    begin
        f2_rounded = ($signed(f1_ctx_reg.acc) + 64'sd2) >>> 2;
        case (f1_ctx_reg.func)
            FUNC_SIN:  f2_last_neg = TRIG_LAST_ODD ^ f1_ctx_reg.neg;
            FUNC_COS:  f2_last_neg = TRIG_LAST_ODD;
            FUNC_LN:   f2_last_neg = LOG_LAST_EVEN ^ (f1_ctx_reg.neg && !LOG_LAST_EVEN);
            default:   f2_last_neg = 1'b0;
        endcase

        f2_result_next = 32'(f2_rounded);
        f2_sat_next    = 1'b0;
        if (f1_ctx_reg.func == FUNC_NONE)
        begin
            f2_result_next = '0;
        end
        else if (f1_ctx_reg.over)
        begin
            f2_result_next = f2_last_neg ? 32'(RES_MIN) : 32'(RES_MAX);
            f2_sat_next    = 1'b1;
        end
        else if (f2_rounded > RES_MAX)
        begin
            f2_result_next = 32'(RES_MAX);
            f2_sat_next    = 1'b1;
        end
        else if (f2_rounded < RES_MIN)
        begin
            f2_result_next = 32'(RES_MIN);
            f2_sat_next    = 1'b1;
        end
    end

    // ---------------------------------------------------------------------------------
    // Output buffer. A word leaving the pipeline goes to the output register when that
    // register is free or being taken, and into the skid entry otherwise. While the
    // skid entry is full the pipeline holds and arguments are stalled.
    // ---------------------------------------------------------------------------------
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_load_f2     = 1'b0;
        out_load_skid   = 1'b0;
        skid_load       = 1'b0;
        if (skid_valid_reg)
        begin
            if (!res_stall)
            begin
                out_load_skid   = 1'b1;
                skid_valid_next = 1'b0;
            end
        end
        else if (!out_valid_reg || !res_stall)
        begin
            out_valid_next = f2_valid_reg;
            out_load_f2    = 1'b1;
        end
        else if (f2_valid_reg)
        begin
            skid_valid_next = 1'b1;
            skid_load       = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg   <= 1'b0;
            s1_valid_reg   <= 1'b0;
            f1_valid_reg   <= 1'b0;
            f2_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                s0_valid_reg <= arg_valid;
                s1_valid_reg <= s0_valid_reg;
                f1_valid_reg <= chain_valid[STEPS];
                f2_valid_reg <= f1_valid_reg;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_func_reg   <= func_t'(func);
            s0_neg_reg    <= argument[31];
            s0_mag_reg    <= s0_mag_next;
            s1_link_reg   <= s1_link_next;
            f1_ctx_reg    <= f1_ctx_next;
            f2_result_reg <= f2_result_next;
            f2_sat_reg    <= f2_sat_next;
        end
        if (out_load_f2)
        begin
            out_result_reg <= f2_result_reg;
            out_sat_reg    <= f2_sat_reg;
        end
        else if (out_load_skid)
        begin
            out_result_reg <= skid_result_reg;
            out_sat_reg    <= skid_sat_reg;
        end
        if (skid_load)
        begin
            skid_result_reg <= f2_result_reg;
            skid_sat_reg    <= f2_sat_reg;
        end
    end

    assign res_valid = out_valid_reg;
    assign result    = out_result_reg;
    assign saturated = out_sat_reg;

    // ---------------------------------------------------------------------------------
    // Checks.
    // ---------------------------------------------------------------------------------

    // The skid entry only fills behind a word that is already waiting at the output.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a word while the output register is empty");

    // A stalled, full buffer keeps its second word.
    a_skid_kept: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && res_stall |=> skid_valid_reg)
        else $error("skid word dropped while the output was stalled");

    // While the buffer is full the series steps must not move.
    a_steps_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |=> $stable(chain_valid))
        else $error("pipeline advanced while the output buffer was full");

    // A clamped result sits at one end of the range.
    a_sat_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && saturated |-> (result == 32'sh7FFF_FFFF || result == 32'sh8000_0000))
        else $error("saturated result is not at a range end");

endmodule

`default_nettype wire
